[design/scd_pkg.sv]
// ----------------------------------------------------------------------------
// Snooping cache directory package
// Sizes, address split, command and bus codes, and the control and status
// bundles shared by the directory modules.
// ----------------------------------------------------------------------------
package scd_pkg;

   localparam int NUM_WAYS   = 8;
   localparam int NUM_SETS   = 128;
   localparam int LINE_BYTES = 32;

   localparam int ADDR_W   = 32;
   localparam int CMD_W    = 3;
   localparam int ID_W     = 4;
   localparam int WAYOUT_W = 3;
   localparam int BUS_W    = 2;

   localparam int WAY_W = $clog2(NUM_WAYS);
   localparam int AGE_W = WAY_W;
   localparam int SET_W = $clog2(NUM_SETS);
   localparam int OFF_W = $clog2(LINE_BYTES);
   localparam int TAG_W = ADDR_W - SET_W - OFF_W;

   localparam logic [AGE_W-1:0] AGE_MRU = AGE_W'(NUM_WAYS - 1);

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_PADDR_W = CSR_IDX_W + 2;

   localparam logic [ID_W-1:0] OWN_ID_RESET    = '0;
   localparam logic            SNOOP_EN_RESET  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CPU_READ   = 3'd0,
      CMD_CPU_WRITE  = 3'd1,
      CMD_SNOOP_READ = 3'd2,
      CMD_SNOOP_WR   = 3'd3,
      CMD_SNOOP_RDX  = 3'd4
   } cmd_type;

   typedef enum logic [BUS_W-1:0] {
      BUS_NONE      = 2'd0,
      BUS_READ      = 2'd1,
      BUS_WRITE     = 2'd2,
      BUS_RDX_WRITE = 2'd3
   } bus_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ID   = 1'b0,
      CSR_SNOOP_EN = 1'b1
   } csr_reg_type;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   typedef logic [NUM_WAYS-1:0][AGE_W-1:0] age_row_type;
   typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_type;

   typedef struct packed {
      logic [NUM_WAYS-1:0] valid;
      age_row_type         ages;
   } meta_row_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_stall;
   } dp_status_type;

   // Ages of a set that has not been touched since reset.
   function automatic age_row_type reset_ages();
      age_row_type r;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r[w] = AGE_W'(w);
      end
      return r;
   endfunction

endpackage

[design/scd_if.sv]
// ----------------------------------------------------------------------------
// Snooping cache directory channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scd_req_if;
   logic                        valid;
   logic                        ready;
   logic [scd_pkg::CMD_W-1:0]   command;
   logic [scd_pkg::ADDR_W-1:0]  address;
   logic [scd_pkg::ID_W-1:0]    requester_id;

   modport source(output valid, command, address, requester_id, input ready);
   modport sink(input valid, command, address, requester_id, output ready);
endinterface

interface scd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [scd_pkg::WAYOUT_W-1:0]  way_used;
   logic [scd_pkg::BUS_W-1:0]     bus_op;
   logic                          invalidated;

   modport source(output valid, hit, way_used, bus_op, invalidated, input ready);
   modport sink(input valid, hit, way_used, bus_op, invalidated, output ready);
endinterface

[design/scd_csr.sv]
// ----------------------------------------------------------------------------
// Snooping cache directory register file
// APB-style access to the cache identifier and the snoop enable.
// ----------------------------------------------------------------------------
module scd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scd_pkg::CSR_PADDR_W-1:0]     csr_paddr,
   input  logic [scd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [scd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output logic [scd_pkg::ID_W-1:0]            own_cache_id,
   output logic                                snoop_enable
);

   logic [scd_pkg::ID_W-1:0] own_id_ff, own_id_in;
   logic                     snoop_en_ff, snoop_en_in;
   logic                     wr_en;
   scd_pkg::csr_reg_type     reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = scd_pkg::csr_reg_type'(
                          csr_paddr[scd_pkg::CSR_PADDR_W-1 -: scd_pkg::CSR_IDX_W]);

   always_comb begin
      own_id_in   = own_id_ff;
      snoop_en_in = snoop_en_ff;
      if (wr_en) begin
         unique case (reg_idx)
            scd_pkg::CSR_OWN_ID:   own_id_in   = csr_pwdata[scd_pkg::ID_W-1:0];
            scd_pkg::CSR_SNOOP_EN: snoop_en_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         scd_pkg::CSR_OWN_ID:   csr_prdata = scd_pkg::CSR_DATA_W'(own_id_ff);
         scd_pkg::CSR_SNOOP_EN: csr_prdata = scd_pkg::CSR_DATA_W'(snoop_en_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff   <= scd_pkg::OWN_ID_RESET;
         snoop_en_ff <= scd_pkg::SNOOP_EN_RESET;
      end else begin
         own_id_ff   <= own_id_in;
         snoop_en_ff <= snoop_en_in;
      end
   end

   assign own_cache_id = own_id_ff;
   assign snoop_enable = snoop_en_ff;

endmodule

[design/scd_ctrl.sv]
// ----------------------------------------------------------------------------
// Snooping cache directory controller
// Sequences each word through set read and then lookup and write-back.
// ----------------------------------------------------------------------------
module scd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  scd_pkg::dp_status_type status,
   output scd_pkg::dp_cmd_type    cmd
);

   scd_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scd_pkg::ST_IDLE: if (req_valid) state_in = scd_pkg::ST_CALC;
         scd_pkg::ST_CALC: if (!status.rsp_stall) state_in = scd_pkg::ST_IDLE;
         default:          state_in = scd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         scd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         scd_pkg::ST_CALC: begin
            // Results are only committed when the output register can take them.
            cmd.commit = !status.rsp_stall;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_commit_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(cmd.capture) || $past(state_ff == scd_pkg::ST_CALC))
      else $error("commit without a captured word");

   a_capture_leads_to_calc: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == scd_pkg::ST_CALC && !req_ready)
      else $error("captured word not processed");

   a_no_capture_and_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

endmodule

[design/scd_dp.sv]
// ----------------------------------------------------------------------------
// Snooping cache directory datapath
// Tag and age/valid memories, parallel way compare, victim choice, age
// update, snoop invalidation and the response register.
// ----------------------------------------------------------------------------
module scd_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  scd_pkg::dp_cmd_type              cmd,
   output scd_pkg::dp_status_type           status,
   input  logic [scd_pkg::CMD_W-1:0]        req_command,
   input  logic [scd_pkg::ADDR_W-1:0]       req_address,
   input  logic [scd_pkg::ID_W-1:0]         req_requester_id,
   input  logic [scd_pkg::ID_W-1:0]         own_cache_id,
   input  logic                             snoop_enable,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [scd_pkg::WAYOUT_W-1:0]     rsp_way_used,
   output logic [scd_pkg::BUS_W-1:0]        rsp_bus_op,
   output logic                             rsp_invalidated
);

   localparam int NW = scd_pkg::NUM_WAYS;

   // Tag memory has no reset: a tag is only compared under its valid bit.
   scd_pkg::tag_row_type  tag_mem  [scd_pkg::NUM_SETS];
   scd_pkg::meta_row_type meta_mem [scd_pkg::NUM_SETS];
   // A set whose flag is clear reads as all invalid with reset ages.
   logic [scd_pkg::NUM_SETS-1:0] row_init_ff;

   logic [scd_pkg::CMD_W-1:0]   cmd_ff;
   logic [scd_pkg::TAG_W-1:0]   tag_ff;
   logic [scd_pkg::SET_W-1:0]   set_ff;
   logic [scd_pkg::ID_W-1:0]    req_id_ff;
   scd_pkg::tag_row_type        tag_rd_ff;
   scd_pkg::meta_row_type       meta_rd_ff;
   logic                        init_rd_ff;
   logic [scd_pkg::SET_W-1:0]   set_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        hit_ff;
   logic [scd_pkg::WAYOUT_W-1:0] way_ff;
   logic [scd_pkg::BUS_W-1:0]   bus_ff;
   logic                        inv_ff;

   logic [NW-1:0]               valid_cur, valid_new, match, max_vec;
   scd_pkg::age_row_type        ages_cur, ages_new, ages_touch;
   scd_pkg::tag_row_type        tag_new;
   scd_pkg::meta_row_type       meta_new;
   logic [scd_pkg::WAY_W-1:0]   hit_way, victim, acc_way;
   logic [scd_pkg::AGE_W-1:0]   old_age;
   logic                        any_match, any_invalid, is_cpu, snoop_act, fill;
   logic                        res_hit, res_inv;
   logic [scd_pkg::WAYOUT_W-1:0] res_way;
   scd_pkg::bus_type            res_bus;

   assign set_in = req_address[scd_pkg::OFF_W +: scd_pkg::SET_W];

   // Capture the word and read its set.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff     <= req_command;
         tag_ff     <= req_address[scd_pkg::ADDR_W-1 -: scd_pkg::TAG_W];
         set_ff     <= set_in;
         req_id_ff  <= req_requester_id;
         tag_rd_ff  <= tag_mem[set_in];
         meta_rd_ff <= meta_mem[set_in];
         init_rd_ff <= row_init_ff[set_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         meta_mem[set_ff] <= meta_new;
         if (fill) begin
            tag_mem[set_ff] <= tag_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
      end else if (cmd.commit) begin
         row_init_ff[set_ff] <= 1'b1;
      end
   end

   always_comb begin
      valid_cur = init_rd_ff ? meta_rd_ff.valid : '0;
      ages_cur  = init_rd_ff ? meta_rd_ff.ages : scd_pkg::reset_ages();
      is_cpu    = cmd_ff == scd_pkg::CMD_CPU_READ || cmd_ff == scd_pkg::CMD_CPU_WRITE;
      snoop_act = (cmd_ff == scd_pkg::CMD_SNOOP_WR || cmd_ff == scd_pkg::CMD_SNOOP_RDX)
                  && snoop_enable && req_id_ff != own_cache_id;

      for (int w = 0; w < NW; w++) begin
         match[w] = valid_cur[w] && tag_rd_ff[w] == tag_ff;
      end
      any_match   = |match;
      any_invalid = ~&valid_cur;

      // Lowest matching way; lowest invalid way, else lowest way of age zero.
      hit_way = '0;
      victim  = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (match[w]) hit_way = scd_pkg::WAY_W'(w);
      end
      for (int w = NW - 1; w >= 0; w--) begin
         if (any_invalid ? !valid_cur[w] : ages_cur[w] == '0) victim = scd_pkg::WAY_W'(w);
      end
      acc_way = any_match ? hit_way : victim;
      old_age = ages_cur[acc_way];

      for (int w = 0; w < NW; w++) begin
         if (scd_pkg::WAY_W'(w) == acc_way) begin
            ages_touch[w] = scd_pkg::AGE_MRU;
         end else if (ages_cur[w] > old_age) begin
            ages_touch[w] = ages_cur[w] - 1'b1;
         end else begin
            ages_touch[w] = ages_cur[w];
         end
         max_vec[w] = ages_touch[w] == scd_pkg::AGE_MRU;
      end

      tag_new          = tag_rd_ff;
      tag_new[acc_way] = tag_ff;
      fill             = is_cpu && !any_match;

      valid_new = valid_cur;
      ages_new  = ages_cur;
      if (is_cpu) begin
         valid_new[acc_way] = 1'b1;
         ages_new           = ages_touch;
      end else if (snoop_act) begin
         valid_new = valid_cur & ~match;
      end
      meta_new.valid = valid_new;
      meta_new.ages  = ages_new;

      res_hit = is_cpu && any_match;
      res_inv = snoop_act && any_match;
      if (is_cpu) begin
         res_way = scd_pkg::WAYOUT_W'(acc_way);
      end else if (res_inv) begin
         res_way = scd_pkg::WAYOUT_W'(hit_way);
      end else begin
         res_way = '0;
      end
      if (cmd_ff == scd_pkg::CMD_CPU_READ) begin
         res_bus = any_match ? scd_pkg::BUS_NONE : scd_pkg::BUS_READ;
      end else if (cmd_ff == scd_pkg::CMD_CPU_WRITE) begin
         res_bus = any_match ? scd_pkg::BUS_WRITE : scd_pkg::BUS_RDX_WRITE;
      end else begin
         res_bus = scd_pkg::BUS_NONE;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff <= res_hit;
         way_ff <= res_way;
         bus_ff <= res_bus;
         inv_ff <= res_inv;
      end
   end

   assign status.rsp_stall = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_way_used     = way_ff;
   assign rsp_bus_op       = bus_ff;
   assign rsp_invalidated  = inv_ff;

   a_commit_fills_output: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten while stalled");

   a_hit_inv_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit && rsp_invalidated))
      else $error("hit and invalidation in one response");

   a_single_mru: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && is_cpu) |-> $onehot(max_vec))
      else $error("age update lost the permutation");

endmodule

[design/snooping_cache_directory_lru.sv]
// Flow: a word is accepted in the idle state, where its set is read into the
// capture registers; in the calc state, once the response register can take it,
// the response is registered and the set is written back. No new word is accepted
// until then, as the memories are read then written back; a response stall holds it.
// Reset: all sets read as empty with ages equal to the way index at once through
// per-set flags, with no clearing pass; registers return to their reset values.
// ----------------------------------------------------------------------------
// Snooping cache directory with counter LRU
// Tag directory of a set-associative write-through cache with snoop
// invalidation: controller, datapath and register file.
// ----------------------------------------------------------------------------
module snooping_cache_directory_lru (
   input  logic                             clock,
   input  logic                             reset,
   scd_req_if.sink                          req_if,
   scd_rsp_if.source                        rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [scd_pkg::CSR_PADDR_W-1:0]  csr_paddr,
   input  logic [scd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [scd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic [scd_pkg::ID_W-1:0] own_cache_id;
   logic                     snoop_enable;
   logic                     req_ready;
   scd_pkg::dp_cmd_type      dp_cmd;
   scd_pkg::dp_status_type   dp_status;
   logic                     rsp_valid;
   logic                     rsp_hit;
   logic [scd_pkg::WAYOUT_W-1:0] rsp_way_used;
   logic [scd_pkg::BUS_W-1:0] rsp_bus_op;
   logic                     rsp_invalidated;

   scd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .own_cache_id (own_cache_id),
      .snoop_enable (snoop_enable)
   );

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   scd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_command      (req_if.command),
      .req_address      (req_if.address),
      .req_requester_id (req_if.requester_id),
      .own_cache_id     (own_cache_id),
      .snoop_enable     (snoop_enable),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_way_used     (rsp_way_used),
      .rsp_bus_op       (rsp_bus_op),
      .rsp_invalidated  (rsp_invalidated)
   );

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.hit         = rsp_hit;
   assign rsp_if.way_used    = rsp_way_used;
   assign rsp_if.bus_op      = rsp_bus_op;
   assign rsp_if.invalidated = rsp_invalidated;

endmodule

[verif/tb_snooping_cache_directory_lru.sv]
// ----------------------------------------------------------------------------
// Snooping cache directory testbench
// Drives CPU reads and writes, snooped bus operations and unused command codes
// into the directory, keeps its own copy of tags, valid bits and LRU ages to
// predict each response, and compares every response with the oldest prediction.
// Random stalls on both channels, one long response stall, and several register
// settings are exercised.
// ----------------------------------------------------------------------------
module tb_snooping_cache_directory_lru;
   import scd_pkg::*;

   typedef struct {
      logic                hit;
      logic [WAYOUT_W-1:0] way;
      bus_type             bus;
      logic                inv;
   } lookup_result;

   class dir_scoreboard;
      logic [TAG_W-1:0] tags  [NUM_SETS][NUM_WAYS];
      bit               valid [NUM_SETS][NUM_WAYS];
      logic [AGE_W-1:0] ages  [NUM_SETS][NUM_WAYS];
      logic [ID_W-1:0]  own_id;
      bit               snoop_en;
      lookup_result     pending[$];
      int               errors;

      function new();
         for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               tags[s][w]  = '1;
               valid[s][w] = 1'b0;
               ages[s][w]  = AGE_W'(w);
            end
         end
         own_id   = OWN_ID_RESET;
         snoop_en = SNOOP_EN_RESET;
         errors   = 0;
      endfunction

      function void set_register(csr_reg_type r, logic [CSR_DATA_W-1:0] v);
         if (r == CSR_OWN_ID) begin
            own_id = v[ID_W-1:0];
         end else begin
            snoop_en = v[0];
         end
      endfunction

      // True when the word can change the directory or ask for a bus operation.
      function bit takes_effect(logic [CMD_W-1:0] c, logic [ID_W-1:0] id);
         return c == CMD_CPU_READ || c == CMD_CPU_WRITE ||
                ((c == CMD_SNOOP_WR || c == CMD_SNOOP_RDX) && snoop_en && id != own_id);
      endfunction

      function void note_access(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                logic [ID_W-1:0] id);
         lookup_result     r;
         logic [SET_W-1:0] s;
         logic [TAG_W-1:0] t;
         logic [AGE_W-1:0] old;
         int               w;
         bit               found;
         s = a[OFF_W +: SET_W];
         t = a[ADDR_W-1 -: TAG_W];
         r = '{hit: 1'b0, way: '0, bus: BUS_NONE, inv: 1'b0};
         found = 1'b0;
         w = 0;
         if (c == CMD_CPU_READ || c == CMD_CPU_WRITE) begin
            for (int i = 0; i < NUM_WAYS; i++) begin
               if (!found && valid[s][i] && tags[s][i] == t) begin
                  found = 1'b1;
                  w = i;
               end
            end
            if (found) begin
               r.hit = 1'b1;
               r.bus = (c == CMD_CPU_READ) ? BUS_NONE : BUS_WRITE;
            end else begin
               // Victim: first empty way, otherwise the least recently used one.
               w = -1;
               for (int i = 0; i < NUM_WAYS; i++) begin
                  if (w < 0 && !valid[s][i]) w = i;
               end
               for (int i = 0; i < NUM_WAYS; i++) begin
                  if (w < 0 && ages[s][i] == 0) w = i;
               end
               if (w < 0) w = 0;
               tags[s][w]  = t;
               valid[s][w] = 1'b1;
               r.bus = (c == CMD_CPU_READ) ? BUS_READ : BUS_RDX_WRITE;
            end
            old = ages[s][w];
            for (int i = 0; i < NUM_WAYS; i++) begin
               if (ages[s][i] > old) ages[s][i] = ages[s][i] - 1'b1;
            end
            ages[s][w] = AGE_MRU;
            r.way = WAYOUT_W'(w);
         end else if (takes_effect(c, id)) begin
            for (int i = 0; i < NUM_WAYS; i++) begin
               if (valid[s][i] && tags[s][i] == t) begin
                  valid[s][i] = 1'b0;
                  if (!r.inv) r.way = WAYOUT_W'(i);
                  r.inv = 1'b1;
               end
            end
         end
         pending.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(lookup_result got);
         lookup_result exp;
         if (pending.size() == 0) begin
            report("response word with no lookup pending");
            return;
         end
         exp = pending.pop_front();
         if (got.hit !== exp.hit || got.way !== exp.way || got.bus !== exp.bus ||
             got.inv !== exp.inv) begin
            report($sformatf("got hit=%b way=%0d bus=%0d inv=%b, expected %b %0d %0d %b",
                             got.hit, got.way, got.bus, got.inv,
                             exp.hit, exp.way, exp.bus, exp.inv));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_PADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   scd_req_if req_bus();
   scd_rsp_if rsp_bus();

   dir_scoreboard sb = new();

   int counted  = 0;
   bit calm     = 1'b0;
   bit rsp_hold = 1'b0;

   localparam int RANDOM_ITEMS = 800;
   localparam int PHASES       = 5;

   snooping_cache_directory_lru uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result('{hit: rsp_bus.hit, way: rsp_bus.way_used,
                              bus: bus_type'(rsp_bus.bus_op),
                              inv: rsp_bus.invalidated});
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_access(req_bus.command, req_bus.address, req_bus.requester_id);
         end
      end
   end

   // Response side: random stall bursts, one long hold-off, none near the end.
   initial begin
      bit held;
      held = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && counted >= 250) begin
            held = 1'b1;
            rsp_hold = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (150) @(negedge clock);
            rsp_hold = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high.
   task automatic push_word(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                            logic [ID_W-1:0] id);
      req_bus.valid        <= 1'b1;
      req_bus.command      <= c;
      req_bus.address      <= a;
      req_bus.requester_id <= id;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_reg_type r, logic [CSR_DATA_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(r, v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Waits for every predicted response, then lets the pipeline settle.
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly a few sets and a small tag pool so lines hit, age out and get
   // snooped; now and then a fully random address.
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] a;
      int                s;
      a = $urandom;
      if ($urandom_range(0, 9) != 0) begin
         s = $urandom_range(0, 4);
         a[OFF_W +: SET_W] = (s == 4) ? '1 : SET_W'(s);
         a[ADDR_W-1 -: TAG_W] = ($urandom_range(0, 15) == 0) ? '1 :
                                TAG_W'($urandom_range(0, 11));
      end
      return a;
   endfunction

   task automatic random_run(int n);
      int                target;
      int                r;
      logic [CMD_W-1:0]  c;
      logic [ID_W-1:0]   id;
      target = counted + n;
      while (counted < target) begin
         r = $urandom_range(0, 99);
         if (r < 35)      c = CMD_CPU_READ;
         else if (r < 60) c = CMD_CPU_WRITE;
         else if (r < 70) c = CMD_SNOOP_READ;
         else if (r < 81) c = CMD_SNOOP_WR;
         else if (r < 92) c = CMD_SNOOP_RDX;
         else             c = CMD_W'($urandom_range(CMD_SNOOP_RDX + 1, (1 << CMD_W) - 1));
         id = ($urandom_range(0, 3) == 0) ? sb.own_id : ID_W'($urandom);
         counted++;
         if (counted > RANDOM_ITEMS * 17 / 20) calm = 1'b1;
         push_word(c, pick_address(), id);
         if (!calm && !rsp_hold && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [ID_W-1:0] ids  [PHASES] = '{4'd9, 4'd0, 4'd15, 4'd15, 4'd0};
      bit              ens  [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      req_bus.valid        = 1'b0;
      req_bus.command      = '0;
      req_bus.address      = '0;
      req_bus.requester_id = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      reset = 1'b1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset register values: miss then hits on one line.
      push_word(CMD_CPU_READ, 32'h0000_0000, 4'd0);
      push_word(CMD_CPU_READ, 32'h0000_0000, 4'd15);
      push_word(CMD_CPU_WRITE, 32'h0000_001F, 4'd0);
      // An all-ones tag must not match the empty ways left by reset.
      push_word(CMD_CPU_READ, 32'hFFFF_F000, 4'd0);
      push_word(CMD_CPU_WRITE, 32'hFFFF_FFFF, 4'd15);
      // Fill set 0, then one more line evicts the least recently used way.
      for (int t = 2; t < 8; t++) begin
         push_word(t[0] ? CMD_CPU_WRITE : CMD_CPU_READ, ADDR_W'(t) << 12, 4'd0);
      end
      push_word(CMD_CPU_READ, 32'h0000_8000, 4'd0);
      // Snoop read and a snoop of our own request leave the line alone.
      push_word(CMD_SNOOP_READ, 32'h0000_3000, 4'd5);
      push_word(CMD_SNOOP_WR, 32'h0000_3000, 4'd0);
      push_word(CMD_SNOOP_WR, 32'h0000_3000, 4'd5);
      push_word(CMD_SNOOP_RDX, 32'hFFFF_FFE0, 4'd15);
      push_word(CMD_SNOOP_RDX, 32'h0000_3000, 4'd5);
      // A write to an invalidated line misses and refills the empty way.
      push_word(CMD_CPU_WRITE, 32'h0000_3004, 4'd0);
      for (int c = CMD_SNOOP_RDX + 1; c < (1 << CMD_W); c++) begin
         push_word(CMD_W'(c), $urandom, 4'd5);
      end
      req_bus.valid <= 1'b0;
      drain();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_OWN_ID, CSR_DATA_W'(ids[p]));
         write_reg(CSR_SNOOP_EN, CSR_DATA_W'(ens[p]));
         random_run(RANDOM_ITEMS / PHASES);
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
